FILE: src/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define CHK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Same, with a message of the caller's choosing.
`define CHK_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

FILE: src/bis_pkg.sv
// Package for the bicubic scaler: widths, register indexes, FSM states
// and the controller/datapath command structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 16;
    localparam int WQ         = 14;

    localparam int DIM_W   = 9;
    localparam int COORD_W = 12;
    localparam int SCALE_W = 24;
    localparam int ADDR_W  = 16;
    localparam int PIX_W   = 32;
    localparam int IDX_W   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int POS_W   = COORD_W + SCALE_W;
    localparam int BASE_W  = POS_W - FRAC_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int CFG_IDX_W = 2;

    localparam int CNT_W        = 5;
    localparam int NUM_WGT      = 8;
    localparam int WGT_CYCLES   = NUM_WGT + 2;
    localparam int TAPS         = 16;
    localparam int DRAIN_CYCLES = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_WGT,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       mem_write;
        logic       capture;
        logic       map_en;
        logic       wgt_issue;
        logic [2:0] wgt_idx;
        logic       rd_issue;
        logic [1:0] rd_row;
        logic [1:0] rd_col;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ctl_status_t;
endpackage
`default_nettype wire

FILE: src/bis_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: src/bis_ctrl.sv
// Sequencer for the scaler: accept, map, weight, 16 reads, drain, output.
// Uses bis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bis_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_command,
    output logic                      s_ready,
    input  wire bis_pkg::ctl_status_t status,
    output bis_pkg::ctl_cmd_t         cmd
);
    import bis_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_command == CMD_SAMPLE) state_next = ST_MAP;
            end
            ST_MAP: state_next = ST_WGT;
            ST_WGT: begin
                if (cnt_reg == CNT_W'(WGT_CYCLES - 1)) state_next = ST_READ;
            end
            ST_READ: begin
                if (cnt_reg == CNT_W'(TAPS - 1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (cnt_reg == CNT_W'(DRAIN_CYCLES - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.mem_write = (state_reg == ST_IDLE) && s_valid && (s_command == CMD_WRITE);
        cmd.capture   = (state_reg == ST_IDLE) && s_valid && (s_command == CMD_SAMPLE);
        cmd.map_en    = (state_reg == ST_MAP);
        cmd.wgt_issue = (state_reg == ST_WGT) && (cnt_reg < CNT_W'(NUM_WGT));
        cmd.wgt_idx   = cnt_reg[2:0];
        cmd.rd_issue  = (state_reg == ST_READ);
        cmd.rd_row    = cnt_reg[3:2];
        cmd.rd_col    = cnt_reg[1:0];
        cmd.out_load  = (state_reg == ST_DONE) && !status.out_busy;
    end
endmodule
`default_nettype wire

FILE: src/bis_datapath.sv
// Scaler datapath: config registers, coordinate mapping, pipelined kernel
// unit, address clamp, source RAM, weighted accumulate, output register.
// Uses bis_pkg and bis_ram.
`timescale 1ns / 1ps
`default_nettype none
module bis_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire bis_pkg::ctl_cmd_t               cmd,
    output bis_pkg::ctl_status_t                 status,
    input  wire logic [bis_pkg::ADDR_W-1:0]      s_pixel_address,
    input  wire logic [bis_pkg::PIX_W-1:0]       s_pixel_in,
    input  wire logic [bis_pkg::COORD_W-1:0]     s_dest_x,
    input  wire logic [bis_pkg::COORD_W-1:0]     s_dest_y,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [bis_pkg::PIX_W-1:0]       m_pixel_out,
    input  wire logic                            cfg_valid,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bis_pkg::SCALE_W-1:0]     cfg_data
);
    import bis_pkg::*;

    localparam int U_W   = WQ + 2;
    localparam int V_W   = 3 * WQ + 8;
    localparam int WT_W  = 2 * U_W;
    localparam int PR_W  = WT_W + 9;
    localparam int ACC_W = 42;
    localparam logic [U_W-1:0] ONE   = U_W'(1) << WQ;
    localparam logic [V_W-1:0] ONE42 = V_W'(1) << (3 * WQ);

    function automatic logic [IDX_W-1:0] clamp_idx(
        input logic [BASE_W-1:0] base,
        input logic [1:0]        off,
        input logic [DIM_W-1:0]  lim
    );
        logic signed [BASE_W+1:0] t;
        logic        [DIM_W-1:0]  hi;
        t  = $signed({2'b00, base}) + $signed({{BASE_W{1'b0}}, off})
             - (BASE_W+2)'(1);
        hi = lim - DIM_W'(1);
        if (t < 0) clamp_idx = '0;
        else if (t > $signed({{(BASE_W+2-DIM_W){1'b0}}, hi})) clamp_idx = hi[IDX_W-1:0];
        else clamp_idx = t[IDX_W-1:0];
    endfunction

    // configuration
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            scale_reg  <= SCALE_W'(65536);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] weff, heff;
    assign weff = (width_reg == '0) ? DIM_W'(1) :
                  (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign heff = (height_reg == '0) ? DIM_W'(1) :
                  (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;

    // coordinate mapping
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic [POS_W-1:0]   posx_reg, posy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dx_reg <= s_dest_x;
            dy_reg <= s_dest_y;
        end
        if (cmd.map_en) begin
            posx_reg <= {{SCALE_W{1'b0}}, dx_reg} * {{COORD_W{1'b0}}, scale_reg};
            posy_reg <= {{SCALE_W{1'b0}}, dy_reg} * {{COORD_W{1'b0}}, scale_reg};
        end
    end

    logic [WQ-1:0] fx, fy, fsel;
    assign fx   = posx_reg[FRAC_BITS-1 -: WQ];
    assign fy   = posy_reg[FRAC_BITS-1 -: WQ];
    assign fsel = cmd.wgt_idx[2] ? fy : fx;

    // kernel unit, three stages: u^2, polynomial, floor
    logic [U_W-1:0] u_in;
    always_comb begin
        case (cmd.wgt_idx[1:0])
            2'd0:    u_in = ONE + U_W'(fsel);
            2'd1:    u_in = U_W'(fsel);
            2'd2:    u_in = ONE - U_W'(fsel);
            default: u_in = (ONE << 1) - U_W'(fsel);
        endcase
    end

    logic [U_W-1:0]   ka_u;
    logic [2*U_W-1:0] ka_u2;
    logic [2:0]       ka_idx, kb_idx;
    logic             ka_vld_reg, kb_vld_reg;
    logic [V_W-1:0]   kb_v;
    logic [3*U_W-1:0] u3;
    logic [V_W-1:0]   v_calc, v_bias;
    logic [U_W-1:0]   w_calc;

    assign u3 = ka_u2 * ka_u;
    always_comb begin
        if (ka_u <= ONE) begin
            v_calc = V_W'(u3) - (V_W'(ka_u2) << (WQ + 1)) + ONE42;
        end else begin
            v_calc = (V_W'(ka_u2) << (WQ + 2)) + (V_W'(ka_u2) << WQ)
                     - V_W'(u3) - (V_W'(ka_u) << (2 * WQ + 3)) + (ONE42 << 2);
        end
    end
    assign v_bias = kb_v + ONE42;
    assign w_calc = v_bias[3*WQ+1 : 2*WQ] - ONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ka_vld_reg <= 1'b0;
            kb_vld_reg <= 1'b0;
        end else begin
            ka_vld_reg <= cmd.wgt_issue;
            kb_vld_reg <= ka_vld_reg;
        end
        ka_u   <= u_in;
        ka_u2  <= u_in * u_in;
        ka_idx <= cmd.wgt_idx;
        kb_v   <= v_calc;
        kb_idx <= ka_idx;
    end

    logic signed [U_W-1:0] wx_reg [4];
    logic signed [U_W-1:0] wy_reg [4];

    always_ff @(posedge aclk) begin
        if (kb_vld_reg) begin
            if (kb_idx[2]) wy_reg[kb_idx[1:0]] <= $signed(w_calc);
            else           wx_reg[kb_idx[1:0]] <= $signed(w_calc);
        end
    end

    // neighbourhood address, clamped at the edges
    logic [IDX_W-1:0]       xx, yy;
    logic [IDX_W+DIM_W-1:0] row_off;
    logic [ADDR_W-1:0]      rd_addr, ram_addr;
    logic [PIX_W-1:0]       ram_rdata;

    assign xx       = clamp_idx(posx_reg[POS_W-1:FRAC_BITS], cmd.rd_col, weff);
    assign yy       = clamp_idx(posy_reg[POS_W-1:FRAC_BITS], cmd.rd_row, heff);
    assign row_off  = yy * weff;
    assign rd_addr  = row_off[ADDR_W-1:0] + ADDR_W'(xx);
    assign ram_addr = cmd.mem_write ? s_pixel_address : rd_addr;

    bis_ram #(.WIDTH(PIX_W), .DEPTH(MEM_DEPTH)) u_src_ram (
        .aclk  (aclk),
        .we    (cmd.mem_write),
        .addr  (ram_addr),
        .wdata (s_pixel_in),
        .rdata (ram_rdata)
    );

    // weight product is registered to line up with the registered read data
    logic signed [WT_W-1:0]  wt_reg;
    logic signed [PR_W-1:0]  prod_reg [4];
    logic signed [ACC_W-1:0] acc_reg  [4];
    logic                    rv1_reg, rv2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv1_reg <= 1'b0;
            rv2_reg <= 1'b0;
        end else begin
            rv1_reg <= cmd.rd_issue;
            rv2_reg <= rv1_reg;
        end
        wt_reg <= wy_reg[cmd.rd_row] * wx_reg[cmd.rd_col];
        for (int c = 0; c < 4; c++) begin
            prod_reg[c] <= wt_reg * $signed({1'b0, ram_rdata[8*c +: 8]});
            if (cmd.map_en) acc_reg[c] <= '0;
            else if (rv2_reg) acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c]);
        end
    end

    // floor, clamp to 0..255, pack
    logic [PIX_W-1:0] pix_calc;
    always_comb begin
        logic signed [ACC_W-2*WQ-1:0] q;
        for (int c = 0; c < 4; c++) begin
            q = acc_reg[c][ACC_W-1:2*WQ];
            if (q < 0) pix_calc[8*c +: 8] = 8'd0;
            else if (q > 255) pix_calc[8*c +: 8] = 8'hFF;
            else pix_calc[8*c +: 8] = q[7:0];
        end
    end

    logic             m_valid_reg;
    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) pix_reg <= pix_calc;
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = pix_reg;
    assign status.out_busy = m_valid_reg && !m_ready;
endmodule
`default_nettype wire

FILE: src/bicubic_image_scaler_unit.sv
// Top level of the bicubic scaler: controller plus datapath.
// Uses bis_pkg, bis_ctrl, bis_datapath.
//
//  channel  | handshake            | payload
//  s_       | s_valid / s_ready    | command, pixel_address, pixel_in, dest_x, dest_y
//  m_       | m_valid / m_ready    | pixel_out
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write item leaves the input ready. A sample item holds the input not ready
// from its accept through the map, kernel weight, 16 single-port RAM read,
// drain and load steps; only then can another item be accepted.
// Reset is synchronous, active low; the source RAM is not cleared.
// A result waiting on m_ready holds the next sample item in its load cycle,
// and the input stays not ready until that load is done.
`timescale 1ns / 1ps
`default_nettype none
module bicubic_image_scaler_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [bis_pkg::ADDR_W-1:0]    s_pixel_address,
    input  wire logic [bis_pkg::PIX_W-1:0]     s_pixel_in,
    input  wire logic [bis_pkg::COORD_W-1:0]   s_dest_x,
    input  wire logic [bis_pkg::COORD_W-1:0]   s_dest_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bis_pkg::PIX_W-1:0]     m_pixel_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bis_pkg::SCALE_W-1:0]   cfg_data
);
    import bis_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    assign cfg_ready = 1'b1;

    bis_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bis_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_pixel_address (s_pixel_address),
        .s_pixel_in      (s_pixel_in),
        .s_dest_x        (s_dest_x),
        .s_dest_y        (s_dest_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );
endmodule
`default_nettype wire

FILE: src/bis_checker.sv
// Port-level checks for the bicubic scaler, bound to the top level.
// Uses bis_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bis_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_command,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [bis_pkg::PIX_W-1:0]     m_pixel_out,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);
    import bis_pkg::*;

    `CHK_ASSERT_MSG(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_pixel_out), "stalled result changed")
    `CHK_ASSERT(a_cfg_ready, aclk, aresetn, cfg_valid |-> cfg_ready)
    `CHK_ASSERT_MSG(a_sample_busy, aclk, aresetn, s_valid && s_ready && s_command == CMD_SAMPLE |=> !s_ready, "ready after sample item")
    `CHK_ASSERT_MSG(a_write_fast, aclk, aresetn, s_valid && s_ready && s_command == CMD_WRITE |=> s_ready, "write item held the input")
endmodule

bind bicubic_image_scaler_unit bis_checker u_bis_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_command   (s_command),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pixel_out (m_pixel_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
`default_nettype wire

FILE: bench/bicubic_image_scaler_unit_tb.sv
// Self-checking bench for bicubic_image_scaler_unit: a queue-fed driver, an
// output monitor and a bit-true scaler predictor. Depends on bis_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module bicubic_image_scaler_unit_tb;
    import bis_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int SETTLE = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic               cmd;
        logic [ADDR_W-1:0]  addr;
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } scaler_item_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [SCALE_W-1:0]   data;
    } reg_write_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = CMD_WRITE;
    logic [ADDR_W-1:0] s_pixel_address = '0;
    logic [PIX_W-1:0] s_pixel_in = '0;
    logic [COORD_W-1:0] s_dest_x = '0;
    logic [COORD_W-1:0] s_dest_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [PIX_W-1:0] m_pixel_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0] cfg_data = '0;

    bicubic_image_scaler_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_pixel_address(s_pixel_address), .s_pixel_in(s_pixel_in),
        .s_dest_x(s_dest_x), .s_dest_y(s_dest_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_out(m_pixel_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // stimulus side
    scaler_item_t pending_items[$];
    reg_write_t   pending_regs[$];
    scaler_item_t item_on_bus;
    bit           filled[MEM_DEPTH];
    int           gen_w, gen_h;
    logic [SCALE_W-1:0] gen_scale;
    bit           quiet = 0;
    bit           idle_on = 1;

    // predictor side
    logic [PIX_W-1:0] src_mem[MEM_DEPTH];
    int               model_w = 1, model_h = 1;
    logic [SCALE_W-1:0] model_scale = 24'h010000;
    logic [PIX_W-1:0] expected_pixels[$];

    int errors = 0;
    int n_writes = 0, n_samples = 0, n_results = 0;
    int gap_cnt = 0, stall_cnt = 0;
    int cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int dim_eff(input logic [DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_WIDTH) return MAX_WIDTH;
        return int'(raw);
    endfunction

    // cubic convolution kernel, a = -1, Q2.14 in, floored Q2.14 out
    function automatic longint cubic_weight(input longint u);
        longint one, one42, v;
        one = longint'(1) << WQ;
        one42 = longint'(1) << (3 * WQ);
        if (u <= one)
            v = u * u * u - 2 * u * u * one + one42;
        else if (u <= 2 * one)
            v = -(u * u * u) + 5 * u * u * one - 8 * u * one * one + 4 * one42;
        else
            v = 0;
        return ((v + one42) >>> (2 * WQ)) - one;
    endfunction

    function automatic logic [PIX_W-1:0] scaled_pixel(input logic [COORD_W-1:0] dx,
                                                      input logic [COORD_W-1:0] dy);
        longint one, pos, f, yy, xx, v;
        longint base[2];
        longint wt[2][4];
        longint acc[4];
        logic [PIX_W-1:0] p, res;
        logic [ADDR_W-1:0] addr;
        one = longint'(1) << WQ;
        for (int a = 0; a < 2; a++) begin
            pos = longint'(a ? dy : dx) * longint'(model_scale);
            f = (pos & ((longint'(1) << FRAC_BITS) - 1)) >> (FRAC_BITS - WQ);
            base[a] = pos >> FRAC_BITS;
            wt[a][0] = cubic_weight(one + f);
            wt[a][1] = cubic_weight(f);
            wt[a][2] = cubic_weight(one - f);
            wt[a][3] = cubic_weight(2 * one - f);
        end
        for (int c = 0; c < 4; c++) acc[c] = 0;
        for (int i = 0; i < 4; i++) begin
            yy = base[1] + i - 1;
            if (yy < 0) yy = 0;
            if (yy > model_h - 1) yy = model_h - 1;
            for (int j = 0; j < 4; j++) begin
                xx = base[0] + j - 1;
                if (xx < 0) xx = 0;
                if (xx > model_w - 1) xx = model_w - 1;
                addr = ADDR_W'(yy * model_w + xx);
                p = src_mem[addr];
                for (int c = 0; c < 4; c++)
                    acc[c] += wt[1][i] * wt[0][j] * longint'(p[8*c +: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            v = acc[c] >>> (2 * WQ);   // floor
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res[8*c +: 8] = v[7:0];
        end
        return res;
    endfunction

    // driver: item channel and register channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (item_on_bus.cmd == CMD_WRITE) begin
                    src_mem[item_on_bus.addr] = item_on_bus.pix;
                    n_writes++;
                end else begin
                    expected_pixels.push_back(scaled_pixel(item_on_bus.dx, item_on_bus.dy));
                    n_samples++;
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_valid <= 1'b0;
                end else if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
                    gap_cnt = $urandom_range(0, 10);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_on_bus = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_command <= item_on_bus.cmd;
                    s_pixel_address <= item_on_bus.addr;
                    s_pixel_in <= item_on_bus.pix;
                    s_dest_x <= item_on_bus.dx;
                    s_dest_y <= item_on_bus.dy;
                end else begin
                    s_valid <= 1'b0;
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIDTH:  model_w = dim_eff(cfg_data[DIM_W-1:0]);
                    REG_HEIGHT: model_h = dim_eff(cfg_data[DIM_W-1:0]);
                    REG_SCALE:  model_scale = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (pending_regs.size() > 0) begin
                    reg_write_t r;
                    r = pending_regs.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= r.idx;
                    cfg_data <= r.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_pixel_out);
                    errors++;
                end else begin
                    logic [PIX_W-1:0] want;
                    want = expected_pixels.pop_front();
                    if (m_pixel_out !== want) begin
                        $display("%0t: pixel_out mismatch, expected %h, got %h",
                                 $time, want, m_pixel_out);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---- stimulus generation ----
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(0, 3))
                0: p[8*c +: 8] = 8'h00;
                1: p[8*c +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return p;
    endfunction

    task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] pix);
        scaler_item_t it;
        it.cmd = CMD_WRITE;
        it.addr = addr;
        it.pix = pix;
        it.dx = COORD_W'($urandom);
        it.dy = COORD_W'($urandom);
        filled[addr] = 1;
        pending_items.push_back(it);
    endtask

    task automatic push_sample(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
        scaler_item_t it;
        it.cmd = CMD_SAMPLE;
        it.addr = ADDR_W'($urandom);
        it.pix = $urandom;
        it.dx = dx;
        it.dy = dy;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_pixels.size() > 0)
            @(posedge aclk);
        // a trailing write gives no result, so let it settle
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic wait_regs();
        while (pending_regs.size() > 0 || cfg_valid) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [DIM_W-1:0] wraw, input logic [DIM_W-1:0] hraw,
                              input logic [SCALE_W-1:0] scl);
        logic [SCALE_W-1:0] d;
        wait_idle();
        d = SCALE_W'($urandom);
        d[DIM_W-1:0] = wraw;
        pending_regs.push_back('{REG_WIDTH, d});
        d = SCALE_W'($urandom);
        d[DIM_W-1:0] = hraw;
        pending_regs.push_back('{REG_HEIGHT, d});
        pending_regs.push_back('{REG_SCALE, scl});
        wait_regs();
        gen_w = dim_eff(wraw);
        gen_h = dim_eff(hraw);
        gen_scale = scl;
    endtask

    function automatic logic [COORD_W-1:0] rand_dest(input int dim);
        longint lim;
        if (gen_scale == 0 || $urandom_range(0, 9) < 3) return COORD_W'($urandom);
        lim = ((longint'(dim) + 2) << FRAC_BITS) / gen_scale;
        if (lim > 4095) lim = 4095;
        return COORD_W'($urandom_range(0, int'(lim)));
    endfunction

    task automatic run_phase(input logic [DIM_W-1:0] wraw, input logic [DIM_W-1:0] hraw,
                             input logic [SCALE_W-1:0] scl, input int n);
        set_config(wraw, hraw, scl);
        idle_on = ($urandom_range(0, 3) != 0);
        for (int a = 0; a < gen_w * gen_h; a++)
            if (!filled[a]) push_write(ADDR_W'(a), rand_pixel());
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0)
                push_sample(rand_dest(gen_w), rand_dest(gen_h));
            else if ($urandom_range(0, 9) == 0)
                push_write(ADDR_W'($urandom), rand_pixel());
            else
                push_write(ADDR_W'($urandom_range(0, gen_w * gen_h - 1)), rand_pixel());
        end
    endtask

    function automatic logic [SCALE_W-1:0] rand_scale();
        case ($urandom_range(0, 6))
            0: return SCALE_W'(0);
            1: return SCALE_W'(1);
            2: return 24'hFFFFFF;
            3: return 24'h010000;
            6: return SCALE_W'($urandom);
            default: return SCALE_W'($urandom_range(24'h002000, 24'h030000));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        if ($urandom_range(0, 7) == 0) return DIM_W'(0);
        return DIM_W'($urandom_range(1, 12));
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 4x4 checkerboard at half step, so both clamps are hit
        set_config(4, 4, 24'h008000);
        pending_regs.push_back('{REG_NONE, 24'hFFFFFF});
        wait_regs();
        for (int a = 0; a < 16; a++)
            push_write(ADDR_W'(a), ((a % 4 + a / 4) % 2) ? 32'hFFFFFFFF : 32'h00000000);
        push_write(16'hFFFF, 32'hFFFFFFFF);
        push_write(16'hAAAA, 32'h55555555);
        push_write(16'h5555, 32'hAAAAAAAA);
        push_sample(0, 0);
        push_sample(1, 1);
        push_sample(2, 3);
        push_sample(12'hFFF, 12'hFFF);
        push_sample(12'hAAA, 12'h555);
        push_sample(12'h555, 12'hAAA);

        // extreme geometries and scales
        run_phase(256, 1, 24'h00C000, 60);
        run_phase(1, 256, 24'hFFFFFF, 40);
        run_phase(511, 0, 24'h000001, 40);
        run_phase(0, 300, 24'h000000, 30);
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) begin
                wait_idle();
                quiet = 1;
            end
            run_phase(rand_dim(), rand_dim(), rand_scale(), 60);
        end

        wait_idle();
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
            errors++;
        end
        $display("Run covered %0d pixel writes and %0d sample requests, %0d results checked,",
                 n_writes, n_samples, n_results);
        $display("over edge-clamped images up to 256 wide or tall and scales from 0 to max.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
